// ----- rtl/tile_depth_bounds_defines.svh -----
// ----------------------------------------------------------------------------
// tile_depth_bounds_defines.svh
// Assertion macros used by the tile depth bounds RTL.
// ----------------------------------------------------------------------------
`ifndef TILE_DEPTH_BOUNDS_DEFINES_SVH
`define TILE_DEPTH_BOUNDS_DEFINES_SVH

// Condition holds at every edge outside reset
`define TDB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define TDB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TDB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tdb_pkg.sv -----
// ----------------------------------------------------------------------------
// tdb_pkg
// Types and constants of the tile depth bounds block.
// ----------------------------------------------------------------------------
package tdb_pkg;

  localparam int CODE_W     = 16;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 12;
  localparam int DEPTH_W    = 41;
  localparam int SCALE_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [CODE_W-1:0] ENC_BIAS   = 16'hFF80;
  localparam logic [CODE_W-1:0] ALL_ONES16 = 16'hFFFF;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_TILE_WIDTH      = 3'd2,
    REG_TILE_HEIGHT     = 3'd3,
    REG_TILES_ACROSS    = 3'd4,
    REG_TILES_DOWN      = 3'd5,
    REG_INV_DEPTH_SCALE = 3'd6
  } cfg_reg_t;

  // Per-column accumulators
  typedef struct packed {
    logic [CODE_W-1:0] max_code;
    logic [CODE_W-1:0] min_nonzero;
    logic [CODE_W-1:0] min_raw;
  } col_acc_t;

  localparam col_acc_t ACC_RESET = '{max_code: '0, min_nonzero: ALL_ONES16,
                                     min_raw: ALL_ONES16};

  // Position of the current pixel in the tile grid
  typedef struct packed {
    logic [ROW_W-1:0] tile_row;
    logic             active;
    logic             last;
  } pix_pos_t;

  // Finished tile, codes not yet turned into depths
  typedef struct packed {
    logic [COL_W-1:0]  tile_col;
    logic [ROW_W-1:0]  tile_row;
    logic              has_sky;
    logic              is_empty;
    logic [CODE_W-1:0] near_code;
    logic [CODE_W-1:0] far_code;
  } tile_codes_t;

  // Finished tile as delivered
  typedef struct packed {
    logic [COL_W-1:0]          tile_col;
    logic [ROW_W-1:0]          tile_row;
    logic                      has_sky;
    logic                      is_empty;
    logic signed [DEPTH_W-1:0] near_depth;
    logic signed [DEPTH_W-1:0] far_depth;
  } tile_res_t;

endpackage

// ----- rtl/tdb_if.sv -----
// ----------------------------------------------------------------------------
// tdb_if
// Valid/ready channels of the tile depth bounds block.
// ----------------------------------------------------------------------------
interface depth_in_if;
  import tdb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] depth_code;

  modport source (output valid, output depth_code, input ready);
  modport sink   (input valid, input depth_code, output ready);
endinterface

interface bounds_out_if;
  import tdb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [COL_W-1:0]          tile_col;
  logic [ROW_W-1:0]          tile_row;
  logic                      has_sky;
  logic                      is_empty;
  logic signed [DEPTH_W-1:0] near_depth;
  logic signed [DEPTH_W-1:0] far_depth;

  modport source (output valid, output tile_col, output tile_row, output has_sky,
                  output is_empty, output near_depth, output far_depth, input ready);
  modport sink   (input valid, input tile_col, input tile_row, input has_sky,
                  input is_empty, input near_depth, input far_depth, output ready);
endinterface

// ----- rtl/tdb_raster.sv -----
// ----------------------------------------------------------------------------
// tdb_raster
// Configuration registers and raster/tile position counters.
// ----------------------------------------------------------------------------
module tdb_raster #(
  parameter int MAX_TILES_X = 128,
  parameter int CW          = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tdb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              step,
  output logic [CW-1:0]                     col_idx,
  output tdb_pkg::pix_pos_t                 pos,
  output logic                              restart,
  output logic [tdb_pkg::SCALE_W-1:0]       scale
);
  import tdb_pkg::*;

  localparam int CCW = $clog2(MAX_TILES_X + 1);
  localparam logic [CCW-1:0] TA_MAX   = CCW'(MAX_TILES_X);
  localparam logic [CCW-1:0] TA_RESET = (MAX_TILES_X < 40) ? TA_MAX : CCW'(40);

  // Geometry, stored already clamped (sizes as size minus one)
  logic [11:0]    w_m1, h_m1;
  logic [7:0]     tw_m1, th_m1;
  logic [CCW-1:0] ta;
  logic [12:0]    td;

  logic [11:0]    pixel_x, pixel_y, pixel_x_next, pixel_y_next;
  logic [7:0]     x_in_tile, y_in_tile, x_in_tile_next, y_in_tile_next;
  logic [CCW-1:0] cur_col, cur_col_next;
  logic [11:0]    cur_row, cur_row_next;
  logic           last_x, last_y;

  function automatic logic [11:0] clamp_img(input logic [12:0] v);
    if (v == 13'd0)         return 12'd0;
    else if (v > 13'd4096)  return 12'd4095;
    else                    return 12'(v - 13'd1);
  endfunction

  function automatic logic [7:0] clamp_tile(input logic [8:0] v);
    if (v == 9'd0)          return 8'd0;
    else if (v > 9'd256)    return 8'd255;
    else                    return 8'(v - 9'd1);
  endfunction

  function automatic logic [CCW-1:0] clamp_ta(input logic [7:0] v);
    if (v == 8'd0)                       return CCW'(1);
    else if (32'(v) > MAX_TILES_X)       return TA_MAX;
    else                                 return CCW'(v);
  endfunction

  function automatic logic [12:0] clamp_td(input logic [12:0] v);
    if (v == 13'd0)         return 13'd1;
    else if (v > 13'd4096)  return 13'd4096;
    else                    return v;
  endfunction

  // Any write to a known register restarts the frame
  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TILE_WIDTH, REG_TILE_HEIGHT,
      REG_TILES_ACROSS, REG_TILES_DOWN, REG_INV_DEPTH_SCALE: begin
        restart = cfg_we;
      end
      default: begin
        restart = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1  <= 12'd639;
      h_m1  <= 12'd479;
      tw_m1 <= 8'd15;
      th_m1 <= 8'd15;
      ta    <= TA_RESET;
      td    <= 13'd30;
      scale <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:     w_m1  <= clamp_img(cfg_data[12:0]);
        REG_IMAGE_HEIGHT:    h_m1  <= clamp_img(cfg_data[12:0]);
        REG_TILE_WIDTH:      tw_m1 <= clamp_tile(cfg_data[8:0]);
        REG_TILE_HEIGHT:     th_m1 <= clamp_tile(cfg_data[8:0]);
        REG_TILES_ACROSS:    ta    <= clamp_ta(cfg_data[7:0]);
        REG_TILES_DOWN:      td    <= clamp_td(cfg_data[12:0]);
        REG_INV_DEPTH_SCALE: scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the pixel now at the input
  assign last_x       = (x_in_tile == tw_m1) || (pixel_x == w_m1);
  assign last_y       = (y_in_tile == th_m1) || (pixel_y == h_m1);
  assign col_idx      = cur_col[CW-1:0];
  assign pos.tile_row = cur_row;
  assign pos.active   = (cur_col < ta) && ({1'b0, cur_row} < td);
  assign pos.last     = last_x && last_y;

  // Counter advance for one accepted pixel
  always_comb begin
    pixel_x_next   = pixel_x;
    pixel_y_next   = pixel_y;
    x_in_tile_next = x_in_tile;
    y_in_tile_next = y_in_tile;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    if (pixel_x == w_m1) begin
      pixel_x_next   = '0;
      x_in_tile_next = '0;
      cur_col_next   = '0;
      if (pixel_y == h_m1) begin
        pixel_y_next   = '0;
        y_in_tile_next = '0;
        cur_row_next   = '0;
      end else begin
        pixel_y_next = pixel_y + 12'd1;
        if (y_in_tile == th_m1) begin
          y_in_tile_next = '0;
          if ({1'b0, cur_row} < td) cur_row_next = cur_row + 12'd1;
        end else begin
          y_in_tile_next = y_in_tile + 8'd1;
        end
      end
    end else begin
      pixel_x_next = pixel_x + 12'd1;
      if (x_in_tile == tw_m1) begin
        x_in_tile_next = '0;
        if (cur_col < ta) cur_col_next = cur_col + CCW'(1);
      end else begin
        x_in_tile_next = x_in_tile + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_x   <= '0;
      pixel_y   <= '0;
      x_in_tile <= '0;
      y_in_tile <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
    end else if (step) begin
      pixel_x   <= pixel_x_next;
      pixel_y   <= pixel_y_next;
      x_in_tile <= x_in_tile_next;
      y_in_tile <= y_in_tile_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
    end
  end

endmodule

// ----- rtl/tdb_accum.sv -----
// ----------------------------------------------------------------------------
// tdb_accum
// Column accumulator memory with read-modify-write and tile close-out.
// ----------------------------------------------------------------------------
module tdb_accum #(
  parameter int MAX_TILES_X = 128,
  parameter int CW          = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [tdb_pkg::CODE_W-1:0]  depth_code,
  input  logic [CW-1:0]               col_idx,
  input  tdb_pkg::pix_pos_t           pos,
  input  logic                        restart,
  output logic                        res_valid,
  output tdb_pkg::tile_codes_t        res,
  output logic [1:0]                  pending
);
  import tdb_pkg::*;

  col_acc_t mem [MAX_TILES_X];
  logic     vld [MAX_TILES_X];

  // Input register
  logic              s1_valid;
  logic [CODE_W-1:0] s1_z;
  logic [CW-1:0]     s1_col;
  pix_pos_t          s1_pos;

  // Registered read and forward path
  col_acc_t rd_data, fwd_data, base, merged, wr_data;
  logic     rd_vld, fwd_sel;
  logic     s1_write, s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_z     <= depth_code;
      s1_col   <= col_idx;
      s1_pos   <= pos;
      rd_data  <= mem[col_idx];
      rd_vld   <= vld[col_idx];
      // entry written this cycle is not yet in the memory read
      fwd_sel  <= s1_write && (s1_col == col_idx);
      fwd_data <= wr_data;
    end
  end

  // Merge the pixel into its column
  always_comb begin
    if (fwd_sel)     base = fwd_data;
    else if (rd_vld) base = rd_data;
    else             base = ACC_RESET;
    merged = base;
    if (s1_z > base.max_code) merged.max_code = s1_z;
    if ((s1_z != '0) && (s1_z < base.min_nonzero)) merged.min_nonzero = s1_z;
    if (s1_z < base.min_raw) merged.min_raw = s1_z;
  end

  assign s1_write = s1_valid && s1_pos.active;
  assign s1_done  = s1_write && s1_pos.last;
  assign wr_data  = s1_pos.last ? ACC_RESET : merged;

  // Memory write
  always_ff @(posedge clk) begin
    if (s1_write) begin
      mem[s1_col] <= wr_data;
    end
  end

  // Valid bits: an invalid entry reads as the cleared value
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < MAX_TILES_X; i++) vld[i] <= 1'b0;
    end else if (s1_write) begin
      vld[s1_col] <= !s1_pos.last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s1_done;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      res.tile_col  <= COL_W'(s1_col);
      res.tile_row  <= s1_pos.tile_row;
      res.has_sky   <= (merged.min_raw == '0);
      res.is_empty  <= (merged.max_code == '0);
      res.near_code <= merged.max_code;
      res.far_code  <= merged.min_nonzero;
    end
  end

  assign pending = {1'b0, s1_done} + {1'b0, res_valid};

endmodule

// ----- rtl/tdb_depth.sv -----
// ----------------------------------------------------------------------------
// tdb_depth
// Turns a tile's near and far codes into Q.16 view depths.
// ----------------------------------------------------------------------------
module tdb_depth (
  input  tdb_pkg::tile_codes_t         codes,
  input  logic [tdb_pkg::SCALE_W-1:0]  scale,
  output tdb_pkg::tile_res_t           res
);
  import tdb_pkg::*;

  logic signed [CODE_W:0]    diff_near, diff_far;
  logic signed [SCALE_W:0]   scale_s;
  logic signed [DEPTH_W:0]   prod_near, prod_far;

  // (bias - code) is 17 bits signed, scale 25 bits non-negative
  assign scale_s   = $signed({1'b0, scale});
  assign diff_near = $signed({1'b0, ENC_BIAS}) - $signed({1'b0, codes.near_code});
  assign diff_far  = $signed({1'b0, ENC_BIAS}) - $signed({1'b0, codes.far_code});
  assign prod_near = diff_near * scale_s;
  assign prod_far  = diff_far * scale_s;

  assign res.tile_col   = codes.tile_col;
  assign res.tile_row   = codes.tile_row;
  assign res.has_sky    = codes.has_sky;
  assign res.is_empty   = codes.is_empty;
  assign res.near_depth = codes.is_empty ? '0 : $signed(prod_near[DEPTH_W-1:0]);
  assign res.far_depth  = codes.is_empty ? '0 : $signed(prod_far[DEPTH_W-1:0]);

endmodule

// ----- rtl/tdb_outq.sv -----
// ----------------------------------------------------------------------------
// tdb_outq
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
`include "tile_depth_bounds_defines.svh"

module tdb_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tdb_pkg::tile_res_t push_data,
  output logic [2:0]         count,
  bounds_out_if.source       tile
);
  import tdb_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam logic [2:0] DEPTH_CNT = 3'(OUTQ_DEPTH);

  tile_res_t     q [OUTQ_DEPTH];
  logic [PW-1:0] head, tail;
  logic          pop;

  assign pop = tile.valid && tile.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + PW'(1);
      if (pop)  head <= head + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

  assign tile.valid      = (count != 3'd0);
  assign tile.tile_col   = q[head].tile_col;
  assign tile.tile_row   = q[head].tile_row;
  assign tile.has_sky    = q[head].has_sky;
  assign tile.is_empty   = q[head].is_empty;
  assign tile.near_depth = q[head].near_depth;
  assign tile.far_depth  = q[head].far_depth;

  `TDB_ASSERT(a_count_range, count <= DEPTH_CNT, "result queue count out of range")
  `TDB_ASSERT_IMP(a_no_overflow, push && !pop, count < DEPTH_CNT, "push into full queue")
  `TDB_ASSERT_NXT(a_pop_drains, pop && !push, count == $past(count) - 3'd1, "pop lost")

endmodule

// ----- rtl/tile_depth_bounds.sv -----
// ----------------------------------------------------------------------------
// tile_depth_bounds
// Per-tile near/far depth bounds of a raster-order 16-bit depth stream.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  pix      in   valid/ready   depth_code
//  tile     out  valid/ready   tile_col, tile_row, has_sky, is_empty,
//                              near_depth, far_depth
//  cfg      in   cfg_we        cfg_index, cfg_data
//
//  One pixel per cycle sustained while pix.ready is high; a tile result
//  passes column memory read, merge, depth multiply and the result queue.
//  The column accumulator memory has one read and one write port; a
//  back-to-back hit on the same column is served from a forward register.
//  Reset and any register write clear the accumulator valid bits at once.
//  pix.ready drops only when the 4-entry result queue plus results in
//  flight would be full, i.e. while tile.ready is held low.
// ----------------------------------------------------------------------------
module tile_depth_bounds #(
  parameter int MAX_TILES_X = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdb_pkg::CFG_DATA_W-1:0]  cfg_data,
  depth_in_if.sink                        pix,
  bounds_out_if.source                    tile
);
  import tdb_pkg::*;

  localparam int CW = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
  localparam logic [2:0] DEPTH_CNT = 3'(OUTQ_DEPTH);

  logic                step, restart, res_valid;
  logic [CW-1:0]       col_idx;
  pix_pos_t            pos;
  logic [SCALE_W-1:0]  scale;
  tile_codes_t         codes;
  tile_res_t           res;
  logic [1:0]          pending;
  logic [2:0]          q_count;

  // Credit check: queue plus results in flight stay within the queue
  assign pix.ready = (q_count + {1'b0, pending}) < DEPTH_CNT;
  assign step      = pix.valid && pix.ready;

  tdb_raster #(.MAX_TILES_X(MAX_TILES_X), .CW(CW)) u_raster (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .col_idx   (col_idx),
    .pos       (pos),
    .restart   (restart),
    .scale     (scale)
  );

  tdb_accum #(.MAX_TILES_X(MAX_TILES_X), .CW(CW)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .depth_code (pix.depth_code),
    .col_idx    (col_idx),
    .pos        (pos),
    .restart    (restart),
    .res_valid  (res_valid),
    .res        (codes),
    .pending    (pending)
  );

  tdb_depth u_depth (
    .codes (codes),
    .scale (scale),
    .res   (res)
  );

  tdb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .count     (q_count),
    .tile      (tile)
  );

endmodule
